// ===== src/triangle_face_normal_top_assert.svh =====
// assertion macros shared by the block
`ifndef TRIANGLE_FACE_NORMAL_TOP_ASSERT_SVH
`define TRIANGLE_FACE_NORMAL_TOP_ASSERT_SVH

// same-cycle implication
`define TFN_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TFN_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/tfn_pkg.sv =====
package tfn_pkg;

    localparam int SLOT_W     = 12;
    localparam int INDEX_W    = 13;
    localparam int NORM_W     = 16;
    localparam int STATUS_W   = 2;
    localparam int EDGE_MAX   = 24;
    localparam int SCALE_W    = 30;
    localparam int SCALE_TOP  = 29;
    localparam int SUM_W      = 62;
    localparam int ROOT_W     = 31;
    localparam int QUOT_W     = 15;
    localparam int FRAC_W     = 14;
    localparam int NUM_W      = 45;
    localparam int ONE_Q14    = 16384;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_FACE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_DEGEN = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    typedef struct packed {
        logic                   valid;
        logic [2:0][SLOT_W-1:0] slot;
        t_status                status;
        logic [2:0]             neg;
    } t_side;

endpackage

// ===== src/tfn_if.sv =====
interface tfn_in_if #(parameter int COORD_WIDTH = 24);
    logic                                valid;
    logic                                ready;
    logic                                op;
    logic [tfn_pkg::SLOT_W-1:0]          vertex_index;
    logic signed [COORD_WIDTH-1:0]       coord_x;
    logic signed [COORD_WIDTH-1:0]       coord_y;
    logic signed [COORD_WIDTH-1:0]       coord_z;
    logic [tfn_pkg::INDEX_W-1:0]         index_a;
    logic [tfn_pkg::INDEX_W-1:0]         index_b;
    logic [tfn_pkg::INDEX_W-1:0]         index_c;

    modport source (
        output valid, op, vertex_index, coord_x, coord_y, coord_z,
               index_a, index_b, index_c,
        input  ready
    );
    modport sink (
        input  valid, op, vertex_index, coord_x, coord_y, coord_z,
               index_a, index_b, index_c,
        output ready
    );
endinterface

interface tfn_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [tfn_pkg::NORM_W-1:0] normal_x;
    logic signed [tfn_pkg::NORM_W-1:0] normal_y;
    logic signed [tfn_pkg::NORM_W-1:0] normal_z;
    logic [tfn_pkg::SLOT_W-1:0]        slot_a;
    logic [tfn_pkg::SLOT_W-1:0]        slot_b;
    logic [tfn_pkg::SLOT_W-1:0]        slot_c;
    logic [tfn_pkg::STATUS_W-1:0]      status;

    modport source (
        output valid, normal_x, normal_y, normal_z, slot_a, slot_b, slot_c, status,
        input  ready
    );
    modport sink (
        input  valid, normal_x, normal_y, normal_z, slot_a, slot_b, slot_c, status,
        output ready
    );
endinterface

// ===== src/triangle_face_normal_top.sv =====
// channel   dir  handshake      payload
// i_item    in   valid/ready    op, vertex_index, coord_x/y/z, index_a/b/c
// o_norm    out  valid/ready    normal_x/y/z, slot_a/b/c, status
//
// one item per cycle sustained while the queue has room and the output is not stalled
// stages: index check and vertex store read, then the edge,
// cross product and scaling stages, 31 square root stages, 1 + 15 divider stages, 1 output
// load items write the vertex store and give no result
// synchronous active-low reset clears control only; vertex store contents are undefined
// an output stall freezes the back pipeline; the 4-entry queue keeps taking items until full
module triangle_face_normal_top #(
    parameter int VERTEX_DEPTH = 4096,
    parameter int COORD_WIDTH  = 24
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tfn_in_if.sink     i_item,
    tfn_out_if.source  o_norm
);

    tfn_pkg::t_side                head;
    logic signed [COORD_WIDTH-1:0] vtx [9];
    logic                          pop;

    tfn_front #(
        .VERTEX_DEPTH (VERTEX_DEPTH),
        .COORD_WIDTH  (COORD_WIDTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .i_pop   (pop),
        .o_head  (head),
        .o_vtx   (vtx)
    );

    tfn_back #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .i_vtx   (vtx),
        .o_pop   (pop),
        .o_norm  (o_norm)
    );

endmodule

// ===== src/tfn_ram.sv =====
module tfn_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/tfn_sqrt.sv =====
module tfn_sqrt (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [tfn_pkg::SUM_W-1:0]   i_rad,
    output logic [tfn_pkg::ROOT_W-1:0]  o_root
);

    localparam int SW = tfn_pkg::SUM_W;
    localparam int RW = tfn_pkg::ROOT_W;

    logic [SW-1:0] r_rem  [RW];
    logic [RW-1:0] r_root [RW];
    logic [SW-1:0] src_rem  [RW];
    logic [RW-1:0] src_root [RW];
    logic [SW-1:0] n_rem  [RW];
    logic [RW-1:0] n_root [RW];

    always_comb begin
        src_rem[0]  = i_rad;
        src_root[0] = '0;
        for (int s = 1; s < RW; s++) begin
            src_rem[s]  = r_rem[s-1];
            src_root[s] = r_root[s-1];
        end
    end

    // one result bit per stage, most significant first
    always_comb begin
        logic [SW:0] trial;
        for (int s = 0; s < RW; s++) begin
            trial = ((SW+1)'(src_root[s]) << (RW - s))
                  | ((SW+1)'(1) << (2 * (RW - 1 - s)));
            if ({1'b0, src_rem[s]} >= trial) begin
                n_rem[s]  = SW'({1'b0, src_rem[s]} - trial);
                n_root[s] = src_root[s] | (RW'(1) << (RW - 1 - s));
            end else begin
                n_rem[s]  = src_rem[s];
                n_root[s] = src_root[s];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int s = 0; s < RW; s++) begin
                r_rem[s]  <= n_rem[s];
                r_root[s] <= n_root[s];
            end
        end
    end

    assign o_root = r_root[RW-1];

endmodule

// ===== src/tfn_div.sv =====
module tfn_div (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [tfn_pkg::NUM_W-1:0]   i_num,
    input  logic [tfn_pkg::ROOT_W-1:0]  i_den,
    output logic [tfn_pkg::QUOT_W-1:0]  o_quot
);

    localparam int NW = tfn_pkg::NUM_W;
    localparam int DW = tfn_pkg::ROOT_W;
    localparam int QW = tfn_pkg::QUOT_W;

    logic [NW-1:0] r_rem [QW];
    logic [DW-1:0] r_den [QW];
    logic [QW-1:0] r_q   [QW];
    logic [NW-1:0] src_rem [QW];
    logic [DW-1:0] src_den [QW];
    logic [QW-1:0] src_q   [QW];
    logic [NW-1:0] n_rem [QW];
    logic [QW-1:0] n_q   [QW];

    always_comb begin
        src_rem[0] = i_num;
        src_den[0] = i_den;
        src_q[0]   = '0;
        for (int s = 1; s < QW; s++) begin
            src_rem[s] = r_rem[s-1];
            src_den[s] = r_den[s-1];
            src_q[s]   = r_q[s-1];
        end
    end

    // restoring division, one quotient bit per stage
    always_comb begin
        logic [NW:0] trial;
        for (int s = 0; s < QW; s++) begin
            trial = (NW+1)'(src_den[s]) << (QW - 1 - s);
            if ({1'b0, src_rem[s]} >= trial) begin
                n_rem[s] = NW'({1'b0, src_rem[s]} - trial);
                n_q[s]   = src_q[s] | (QW'(1) << (QW - 1 - s));
            end else begin
                n_rem[s] = src_rem[s];
                n_q[s]   = src_q[s];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int s = 0; s < QW; s++) begin
                r_rem[s] <= n_rem[s];
                r_den[s] <= src_den[s];
                r_q[s]   <= n_q[s];
            end
        end
    end

    assign o_quot = r_q[QW-1];

endmodule

// ===== src/tfn_front.sv =====
module tfn_front #(
    parameter int VERTEX_DEPTH = 4096,
    parameter int COORD_WIDTH  = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    tfn_in_if.sink                        i_item,
    input  logic                          i_pop,
    output tfn_pkg::t_side                o_head,
    output logic signed [COORD_WIDTH-1:0] o_vtx [9]
);

    `include "triangle_face_normal_top_assert.svh"

    localparam int AW = $clog2(VERTEX_DEPTH);
    localparam int IW = tfn_pkg::INDEX_W;
    localparam int FD = tfn_pkg::FIFO_DEPTH;
    localparam int FA = tfn_pkg::FIFO_AW;

    logic [IW-1:0]          idx    [3];
    logic [IW-1:0]          slot13 [3];
    logic [2:0]             bad;
    logic [AW-1:0]          raddr  [3];
    logic [AW-1:0]          waddr;
    logic [COORD_WIDTH-1:0] wdata  [3];
    logic [COORD_WIDTH-1:0] rdata  [9];
    logic                   accept;
    logic                   load_we;
    logic                   push;
    logic                   pop;
    tfn_pkg::t_side         n_f1;
    tfn_pkg::t_side         r_f1;

    tfn_pkg::t_side                r_fq_side [FD];
    logic signed [COORD_WIDTH-1:0] r_fq_vtx  [FD][9];
    logic [FA-1:0]                 r_wp;
    logic [FA-1:0]                 r_rp;
    logic [FA:0]                   r_count;

    assign idx[0] = i_item.index_a;
    assign idx[1] = i_item.index_b;
    assign idx[2] = i_item.index_c;

    always_comb begin
        for (int v = 0; v < 3; v++) begin
            slot13[v] = idx[v] - IW'(1);
            bad[v]    = (idx[v] == '0) || (32'(idx[v]) > 32'(VERTEX_DEPTH));
            raddr[v]  = AW'(slot13[v]);
        end
    end

    assign accept  = i_item.valid && i_item.ready;
    assign load_we = accept && (i_item.op == tfn_pkg::OP_LOAD)
                     && (32'(i_item.vertex_index) < 32'(VERTEX_DEPTH));
    assign waddr    = AW'(i_item.vertex_index);
    assign wdata[0] = i_item.coord_x;
    assign wdata[1] = i_item.coord_y;
    assign wdata[2] = i_item.coord_z;

    // one copy of each coordinate store per face corner
    for (genvar v = 0; v < 3; v++) begin : g_corner
        for (genvar ax = 0; ax < 3; ax++) begin : g_axis
            tfn_ram #(
                .WIDTH (COORD_WIDTH),
                .DEPTH (VERTEX_DEPTH)
            ) u_ram (
                .i_clk   (i_clk),
                .i_we    (load_we),
                .i_waddr (waddr),
                .i_wdata (wdata[ax]),
                .i_raddr (raddr[v]),
                .o_rdata (rdata[v*3+ax])
            );
        end
    end

    always_comb begin
        n_f1        = '0;
        n_f1.valid  = accept && (i_item.op == tfn_pkg::OP_FACE);
        n_f1.status = (|bad) ? tfn_pkg::ST_RANGE : tfn_pkg::ST_OK;
        for (int v = 0; v < 3; v++) begin
            n_f1.slot[v] = bad[v] ? '0 : slot13[v][tfn_pkg::SLOT_W-1:0];
        end
    end

    assign push = r_f1.valid;
    assign pop  = i_pop && (r_count != '0);

    // room for the item in flight through the store read
    assign i_item.ready = (({1'b0, r_count} + (FA+2)'(r_f1.valid)) < (FA+2)'(FD));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1    <= '0;
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_f1 <= n_f1;
            if (push) begin
                r_wp <= r_wp + FA'(1);
            end
            if (pop) begin
                r_rp <= r_rp + FA'(1);
            end
            r_count <= r_count + (FA+1)'(push) - (FA+1)'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_fq_side[r_wp] <= r_f1;
            for (int k = 0; k < 9; k++) begin
                r_fq_vtx[r_wp][k] <= $signed(rdata[k]);
            end
        end
    end

    always_comb begin
        o_head       = r_fq_side[r_rp];
        o_head.valid = (r_count != '0);
        for (int k = 0; k < 9; k++) begin
            o_vtx[k] = r_fq_vtx[r_rp][k];
        end
    end

    `TFN_ASSERT_IMP(a_fq_bound, 1'b1, r_count <= (FA+1)'(FD), "queue count beyond depth")
    `TFN_ASSERT_IMP(a_fq_room, r_f1.valid, r_count < (FA+1)'(FD), "queue full at push")
    `TFN_ASSERT_IMP(a_fq_ptr, 1'b1, r_count[FA-1:0] == FA'(r_wp - r_rp), "queue pointers out of step")

endmodule

// ===== src/tfn_back.sv =====
module tfn_back #(
    parameter int COORD_WIDTH = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tfn_pkg::t_side                i_head,
    input  logic signed [COORD_WIDTH-1:0] i_vtx [9],
    output logic                          o_pop,
    tfn_out_if.source                     o_norm
);

    `include "triangle_face_normal_top_assert.svh"

    localparam int ES   = (COORD_WIDTH > tfn_pkg::EDGE_MAX) ? COORD_WIDTH - tfn_pkg::EDGE_MAX : 0;
    localparam int EW   = COORD_WIDTH + 1 - ES;
    localparam int MW   = 2 * EW;
    localparam int CRW  = MW + 1;
    localparam int NG   = (MW + 7) / 8;
    localparam int GW   = $clog2(NG);
    localparam int POSW = GW + 3;
    localparam int SCW  = tfn_pkg::SCALE_W;
    localparam int SQW  = 2 * tfn_pkg::SCALE_W;
    localparam int SW   = tfn_pkg::SUM_W;
    localparam int RW   = tfn_pkg::ROOT_W;
    localparam int QW   = tfn_pkg::QUOT_W;
    localparam int NW   = tfn_pkg::NUM_W;
    localparam int OW   = tfn_pkg::NORM_W;

    logic en;

    tfn_pkg::t_side          r_sd [9];
    logic signed [EW-1:0]    r_e1 [3];
    logic signed [EW-1:0]    r_e2 [3];
    logic signed [MW-1:0]    r_pr [6];
    logic signed [CRW-1:0]   r_cr [3];
    logic [MW-1:0]           r_mg3 [3];
    logic [MW-1:0]           r_mg4 [3];
    logic [MW-1:0]           r_orv;
    logic [MW-1:0]           r_mg5 [3];
    logic [POSW-1:0]         r_pos;
    logic [SCW-1:0]          r_sc [3];
    logic [SQW-1:0]          r_sq [3];
    logic [SCW-1:0]          r_sc7 [3];
    logic [SW-1:0]           r_sum;
    logic [SCW-1:0]          r_sc8 [3];
    tfn_pkg::t_side          r_dq_sd [RW];
    logic [SCW-1:0]          r_dq_sc [RW][3];
    tfn_pkg::t_side          r_pd_sd;
    logic [NW-1:0]           r_num [3];
    logic [RW-1:0]           r_len;
    tfn_pkg::t_side          r_dv_sd [QW];
    logic                    r_out_valid;
    logic signed [OW-1:0]    r_out_n [3];
    logic [2:0][tfn_pkg::SLOT_W-1:0] r_out_slot;
    tfn_pkg::t_status        r_out_st;

    logic signed [COORD_WIDTH:0] dif1 [3];
    logic signed [COORD_WIDTH:0] dif2 [3];
    logic signed [EW-1:0]        n_e1 [3];
    logic signed [EW-1:0]        n_e2 [3];
    tfn_pkg::t_side              n_sd0;
    tfn_pkg::t_side              n_sd3;
    tfn_pkg::t_side              n_sd5;
    logic [MW-1:0]               n_mg3 [3];
    logic [NG*8-1:0]             orp;
    logic [GW-1:0]               top_g;
    logic [7:0]                  top_byte;
    logic [2:0]                  top_b;
    logic [SCW-1:0]              n_sc [3];
    logic [RW-1:0]               root;
    logic [QW-1:0]               quot [3];
    logic signed [OW-1:0]        n_out [3];

    assign en    = !r_out_valid || o_norm.ready;
    assign o_pop = en && i_head.valid;

    always_comb begin
        n_sd0 = i_head;
        for (int ax = 0; ax < 3; ax++) begin
            dif1[ax] = (COORD_WIDTH+1)'(i_vtx[3+ax]) - (COORD_WIDTH+1)'(i_vtx[ax]);
            dif2[ax] = (COORD_WIDTH+1)'(i_vtx[6+ax]) - (COORD_WIDTH+1)'(i_vtx[ax]);
            n_e1[ax] = EW'(dif1[ax] >>> ES);
            n_e2[ax] = EW'(dif2[ax] >>> ES);
        end
    end

    always_comb begin
        n_sd3 = r_sd[2];
        for (int ax = 0; ax < 3; ax++) begin
            n_sd3.neg[ax] = r_cr[ax][CRW-1];
            n_mg3[ax]     = r_cr[ax][CRW-1] ? MW'(-r_cr[ax]) : MW'(r_cr[ax]);
        end
    end

    // top set bit of the largest magnitude, byte group first
    always_comb begin
        orp   = (NG*8)'(r_orv);
        top_g = '0;
        for (int g = 0; g < NG; g++) begin
            if (|orp[g*8 +: 8]) begin
                top_g = GW'(g);
            end
        end
        top_byte = orp[top_g*8 +: 8];
        top_b    = '0;
        for (int b = 0; b < 8; b++) begin
            if (top_byte[b]) begin
                top_b = 3'(b);
            end
        end
        n_sd5 = r_sd[4];
        if (r_sd[4].status == tfn_pkg::ST_OK && r_orv == '0) begin
            n_sd5.status = tfn_pkg::ST_DEGEN;
        end
    end

    // scale so the largest magnitude lands in [2^29, 2^30)
    always_comb begin
        for (int ax = 0; ax < 3; ax++) begin
            if (int'(r_pos) > tfn_pkg::SCALE_TOP) begin
                n_sc[ax] = SCW'(r_mg5[ax] >> (r_pos - POSW'(tfn_pkg::SCALE_TOP)));
            end else begin
                n_sc[ax] = SCW'((MW+SCW)'(r_mg5[ax]) << (POSW'(tfn_pkg::SCALE_TOP) - r_pos));
            end
        end
    end

    tfn_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_rad  (r_sum),
        .o_root (root)
    );

    for (genvar ax = 0; ax < 3; ax++) begin : g_div
        tfn_div u_div (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_num  (r_num[ax]),
            .i_den  (r_len),
            .o_quot (quot[ax])
        );
    end

    always_comb begin
        for (int ax = 0; ax < 3; ax++) begin
            if (r_dv_sd[QW-1].status != tfn_pkg::ST_OK) begin
                n_out[ax] = '0;
            end else if (r_dv_sd[QW-1].neg[ax]) begin
                n_out[ax] = -$signed({1'b0, quot[ax]});
            end else begin
                n_out[ax] = $signed({1'b0, quot[ax]});
            end
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sd        <= '{default: '0};
            r_dq_sd     <= '{default: '0};
            r_pd_sd     <= '0;
            r_dv_sd     <= '{default: '0};
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_sd[0] <= n_sd0;
            r_sd[1] <= r_sd[0];
            r_sd[2] <= r_sd[1];
            r_sd[3] <= n_sd3;
            r_sd[4] <= r_sd[3];
            r_sd[5] <= n_sd5;
            r_sd[6] <= r_sd[5];
            r_sd[7] <= r_sd[6];
            r_sd[8] <= r_sd[7];
            r_dq_sd[0] <= r_sd[8];
            for (int k = 1; k < RW; k++) begin
                r_dq_sd[k] <= r_dq_sd[k-1];
            end
            r_pd_sd    <= r_dq_sd[RW-1];
            r_dv_sd[0] <= r_pd_sd;
            for (int k = 1; k < QW; k++) begin
                r_dv_sd[k] <= r_dv_sd[k-1];
            end
            r_out_valid <= r_dv_sd[QW-1].valid;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int ax = 0; ax < 3; ax++) begin
                r_e1[ax] <= n_e1[ax];
                r_e2[ax] <= n_e2[ax];
            end
            r_pr[0] <= MW'(r_e1[1]) * MW'(r_e2[2]);
            r_pr[1] <= MW'(r_e1[2]) * MW'(r_e2[1]);
            r_pr[2] <= MW'(r_e1[2]) * MW'(r_e2[0]);
            r_pr[3] <= MW'(r_e1[0]) * MW'(r_e2[2]);
            r_pr[4] <= MW'(r_e1[0]) * MW'(r_e2[1]);
            r_pr[5] <= MW'(r_e1[1]) * MW'(r_e2[0]);
            r_cr[0] <= CRW'(r_pr[0]) - CRW'(r_pr[1]);
            r_cr[1] <= CRW'(r_pr[2]) - CRW'(r_pr[3]);
            r_cr[2] <= CRW'(r_pr[4]) - CRW'(r_pr[5]);
            r_orv <= r_mg3[0] | r_mg3[1] | r_mg3[2];
            r_pos <= {top_g, top_b};
            for (int ax = 0; ax < 3; ax++) begin
                r_mg3[ax] <= n_mg3[ax];
                r_mg4[ax] <= r_mg3[ax];
                r_mg5[ax] <= r_mg4[ax];
                r_sc[ax]  <= n_sc[ax];
                r_sq[ax]  <= SQW'(r_sc[ax]) * SQW'(r_sc[ax]);
                r_sc7[ax] <= r_sc[ax];
                r_sc8[ax] <= r_sc7[ax];
                r_dq_sc[0][ax] <= r_sc8[ax];
                for (int k = 1; k < RW; k++) begin
                    r_dq_sc[k][ax] <= r_dq_sc[k-1][ax];
                end
                r_num[ax] <= (NW'(r_dq_sc[RW-1][ax]) << tfn_pkg::FRAC_W) + NW'(root >> 1);
            end
            r_sum <= SW'(r_sq[0]) + SW'(r_sq[1]) + SW'(r_sq[2]);
            r_len <= root;
            for (int ax = 0; ax < 3; ax++) begin
                r_out_n[ax] <= n_out[ax];
            end
            r_out_slot <= r_dv_sd[QW-1].slot;
            r_out_st   <= r_dv_sd[QW-1].status;
        end
    end

    assign o_norm.valid    = r_out_valid;
    assign o_norm.normal_x = r_out_n[0];
    assign o_norm.normal_y = r_out_n[1];
    assign o_norm.normal_z = r_out_n[2];
    assign o_norm.slot_a   = r_out_slot[0];
    assign o_norm.slot_b   = r_out_slot[1];
    assign o_norm.slot_c   = r_out_slot[2];
    assign o_norm.status   = r_out_st;

    `TFN_ASSERT_IMP(a_bad_zero, r_out_valid && r_out_st != tfn_pkg::ST_OK, r_out_n[0] == '0 && r_out_n[1] == '0 && r_out_n[2] == '0, "nonzero normal on failed face")
    `TFN_ASSERT_IMP(a_unit_bound, r_out_valid && r_out_st == tfn_pkg::ST_OK, r_out_n[0] <= 16384 && r_out_n[0] >= -16384 && r_out_n[1] <= 16384 && r_out_n[1] >= -16384 && r_out_n[2] <= 16384 && r_out_n[2] >= -16384, "normal component beyond one")
    `TFN_ASSERT_IMP(a_degen_scale, r_sd[6].valid && r_sd[6].status == tfn_pkg::ST_DEGEN, r_sc[0] == '0 && r_sc[1] == '0 && r_sc[2] == '0, "degenerate face with nonzero cross product")

endmodule
